>>> sv/fiq_pkg.sv
// ----------------------------------------------------------------------------
// fiq_pkg
// Shared types and constants for the falling-edge interrupt queue.
// ----------------------------------------------------------------------------
package fiq_pkg;

    // Queue and channel geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int CHANNELS    = 11;

    localparam int CHAN_W = 4;                          // channel number / mask lines
    localparam int QAW    = $clog2(QUEUE_DEPTH);        // queue slot index
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);    // queue fill count
    localparam int CLR_W  = 5;                          // clear level register
    localparam int CMP_W  = (FILL_W > CLR_W) ? FILL_W : CLR_W;
    localparam int CFG_W  = (CHANNELS > CLR_W) ? CHANNELS : CLR_W;

    // Reset values of the configuration registers and outputs
    localparam logic [CHANNELS-1:0] ENABLE_RST    = CHANNELS'(2042);
    localparam logic [CLR_W-1:0]    CLEAR_LVL_RST = CLR_W'(8);
    localparam logic [CHAN_W-1:0]   MASK_IDLE     = {CHAN_W{1'b1}};

    // Decoupling queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Command codes
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_STROBE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_ENABLE    = 1'b0,
        REG_CLEAR_LVL = 1'b1
    } t_reg_idx;

    // Classified item handed from front to back
    typedef struct packed {
        logic                sample;
        logic                strobe;
        logic                clear;
        logic [CHANNELS-1:0] pins;
    } t_item;

    // Channel queue storage
    typedef logic [CHAN_W-1:0] t_store [QUEUE_DEPTH];

endpackage

>>> sv/fiq_front.sv
// ----------------------------------------------------------------------------
// fiq_front
// Accepts command items, decodes them into operation flags and hands them
// to the decoupling queue.
// ----------------------------------------------------------------------------
module fiq_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [fiq_pkg::CHANNELS-1:0]  i_pin_levels,
    output logic                          o_push,
    output fiq_pkg::t_item                o_item,
    input  logic                          i_full
);
    import fiq_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_ready;
    logic  w_accept;

    // Take a new item when the holding stage is empty or drains this cycle
    assign w_ready  = !r_valid || !i_full;
    assign busy     = !w_ready;
    assign w_accept = start && w_ready;
    assign o_push   = r_valid && !i_full;
    assign o_item   = r_item;

    // Decode the command into operation flags
    always_comb begin
        n_item        = '0;
        n_item.pins   = i_pin_levels;
        case (t_cmd'(i_command))
            CMD_SAMPLE: n_item.sample = 1'b1;
            CMD_STROBE: n_item.strobe = 1'b1;
            CMD_CLEAR:  n_item.clear  = 1'b1;
            default:    ;
        endcase
    end

    // Hold the decoded item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

>>> sv/fiq_fifo.sv
// ----------------------------------------------------------------------------
// fiq_fifo
// Short first-in, first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module fiq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fiq_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fiq_pkg::t_item o_item
);
    import fiq_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // A push never arrives while full: the front holds its item instead
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("fiq_fifo: push while full");

endmodule

>>> sv/fiq_back.sv
// ----------------------------------------------------------------------------
// fiq_back
// Executes one item per cycle: edge detection and queueing, strobe pops,
// clears, the overflow rule and request presentation. Registers the result.
// ----------------------------------------------------------------------------
module fiq_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  fiq_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic [fiq_pkg::CHANNELS-1:0]  i_enable,
    input  logic [fiq_pkg::CLR_W-1:0]     i_clear_level,
    output logic                          o_done,
    output logic [fiq_pkg::CHAN_W-1:0]    o_mask_lines,
    output logic                          o_irq_line,
    output logic                          o_busy_res,
    output logic [fiq_pkg::FILL_W-1:0]    o_queue_count,
    output logic [fiq_pkg::CHAN_W-1:0]    o_head_channel,
    output logic                          o_live,
    output logic                          o_queue_cleared,
    output logic                          o_edges_dropped
);
    import fiq_pkg::*;

    // Architectural state
    t_store              r_store;
    logic [FILL_W-1:0]   r_fill;
    logic [CHANNELS-1:0] r_prev;
    logic                r_armed;
    logic                r_await;
    logic [CHAN_W-1:0]   r_mask;
    logic                r_req;

    t_store              n_store;
    logic [FILL_W-1:0]   n_fill;
    logic [CHANNELS-1:0] n_prev;
    logic                n_armed;
    logic                n_await;
    logic [CHAN_W-1:0]   n_mask;
    logic                n_req;
    logic                n_cleared;
    logic                n_dropped;
    logic [CHAN_W-1:0]   n_head;

    logic [CHANNELS-1:0] v_fell;
    logic [FILL_W:0]     v_pos;
    logic                v_flush;

    assign o_pop = i_valid;

    // Work out the next state for the item at the queue head
    always_comb begin
        n_store   = r_store;
        n_fill    = r_fill;
        n_prev    = r_prev;
        n_armed   = r_armed;
        n_await   = r_await;
        n_mask    = r_mask;
        n_req     = r_req;
        n_cleared = 1'b0;
        n_dropped = 1'b0;
        v_fell    = ~i_item.pins & r_prev;
        v_pos     = {1'b0, r_fill};
        v_flush   = 1'b0;

        // Pin sample: queue fallen channels from 1 upward in ascending order
        if (i_item.sample && r_armed && (((i_item.pins ^ r_prev) & i_enable) != '0)) begin
            for (int i = 1; i < CHANNELS; i++) begin
                if (v_fell[i]) begin
                    if (v_pos < (FILL_W + 1)'(QUEUE_DEPTH)) begin
                        n_store[v_pos[QAW-1:0]] = CHAN_W'(i);
                        v_pos = v_pos + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
            end
            n_fill = v_pos[FILL_W-1:0];
            n_prev = i_item.pins;
        end

        // Strobe: release lines, pop the head or arm the block
        if (i_item.strobe) begin
            n_mask  = MASK_IDLE;
            n_req   = 1'b1;
            n_await = 1'b0;
            if (r_armed) begin
                if (r_fill != '0) begin
                    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                        n_store[j] = r_store[j + 1];
                    end
                    n_store[QUEUE_DEPTH - 1] = '0;
                    n_fill = r_fill - 1'b1;
                end
            end else begin
                n_armed = 1'b1;
                n_prev  = i_item.pins;
            end
        end

        // Overflow rule, checked once armed; a clear command leaves nothing to flush
        if (n_armed && !i_item.clear && (CMP_W'(n_fill) > CMP_W'(i_clear_level))) begin
            n_cleared = 1'b1;
        end
        v_flush = i_item.clear || n_cleared;

        // Clear: empty the queue and release the lines
        if (v_flush) begin
            for (int j = 0; j < QUEUE_DEPTH; j++) begin
                n_store[j] = '0;
            end
            n_fill  = '0;
            n_prev  = i_item.pins;
            n_mask  = MASK_IDLE;
            n_req   = 1'b1;
            n_await = 1'b0;
        end

        // Present the head channel when idle and something waits
        if (n_armed && !n_await && (n_fill != '0)) begin
            n_mask  = ~n_store[0];
            n_req   = 1'b0;
            n_await = 1'b1;
        end

        n_head = (n_fill != '0) ? n_store[0] : '0;
    end

    // Update control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_prev  <= '0;
            r_armed <= 1'b0;
            r_await <= 1'b0;
            r_mask  <= MASK_IDLE;
            r_req   <= 1'b1;
            o_done  <= 1'b0;
            for (int j = 0; j < QUEUE_DEPTH; j++) begin
                r_store[j] <= '0;
            end
        end else begin
            o_done <= i_valid;
            if (i_valid) begin
                r_store <= n_store;
                r_fill  <= n_fill;
                r_prev  <= n_prev;
                r_armed <= n_armed;
                r_await <= n_await;
                r_mask  <= n_mask;
                r_req   <= n_req;
            end
        end
    end

    // Register the result item
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            o_mask_lines    <= n_mask;
            o_irq_line      <= n_req;
            o_busy_res      <= n_await;
            o_queue_count   <= n_fill;
            o_head_channel  <= n_head;
            o_live          <= n_armed;
            o_queue_cleared <= n_cleared;
            o_edges_dropped <= n_dropped;
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("fiq_back: queue fill beyond depth");

    a_req_matches_await: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req == !r_await)
        else $error("fiq_back: request line disagrees with pending strobe");

    a_armed_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |=> r_armed)
        else $error("fiq_back: block disarmed without reset");

endmodule

>>> sv/falling_edge_interrupt_queue.sv
// Results pass the front holding stage, the queue and the result registers.
// Throughput: one item per cycle while busy is low; the back retires one per cycle.
// Results come out in acceptance order, one per item, with no stall.
// Reset (synchronous, active low) disarms the block, empties the queue,
// releases the internal mask and request state and restores register defaults.
// ----------------------------------------------------------------------------
// falling_edge_interrupt_queue
// Interrupt aggregator: queues falling-edge channel numbers and presents
// them one at a time on mask and request lines.
// ----------------------------------------------------------------------------
module falling_edge_interrupt_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_command,
    input  logic [fiq_pkg::CHANNELS-1:0]  i_pin_levels,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [fiq_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                          o_done,
    output logic [fiq_pkg::CHAN_W-1:0]    o_mask_lines,
    output logic                          o_irq_line,
    output logic                          o_busy_res,
    output logic [fiq_pkg::FILL_W-1:0]    o_queue_count,
    output logic [fiq_pkg::CHAN_W-1:0]    o_head_channel,
    output logic                          o_live,
    output logic                          o_queue_cleared,
    output logic                          o_edges_dropped
);
    import fiq_pkg::*;

    logic [CHANNELS-1:0] r_enable;
    logic [CLR_W-1:0]    r_clear_level;

    logic  w_push;
    t_item w_front_item;
    logic  w_full;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= ENABLE_RST;
            r_clear_level <= CLEAR_LVL_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE:    r_enable      <= i_cfg_data[CHANNELS-1:0];
                REG_CLEAR_LVL: r_clear_level <= i_cfg_data[CLR_W-1:0];
                default:       ;
            endcase
        end
    end

    fiq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_pin_levels (i_pin_levels),
        .o_push       (w_push),
        .o_item       (w_front_item),
        .i_full       (w_full)
    );

    fiq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    fiq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_q_valid),
        .i_item          (w_q_item),
        .o_pop           (w_pop),
        .i_enable        (r_enable),
        .i_clear_level   (r_clear_level),
        .o_done          (o_done),
        .o_mask_lines    (o_mask_lines),
        .o_irq_line      (o_irq_line),
        .o_busy_res      (o_busy_res),
        .o_queue_count   (o_queue_count),
        .o_head_channel  (o_head_channel),
        .o_live          (o_live),
        .o_queue_cleared (o_queue_cleared),
        .o_edges_dropped (o_edges_dropped)
    );

endmodule
